### rtl/lrf_pkg.sv
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared types and constants for the line loss recovery sequencer.
// ----------------------------------------------------------------------------
package lrf_pkg;

	localparam int unsigned ErrW   = 12;
	localparam int unsigned MaxErrW = 11;
	localparam int unsigned TimeW  = 32;
	localparam int unsigned DurW   = 16;
	localparam int unsigned CfgW   = 16;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [MaxErrW-1:0] AdvanceMaxErrRst  = 11'd200;
	localparam logic [DurW-1:0]    AdvanceTimeRst    = 16'd300;
	localparam logic [DurW-1:0]    PivotTimeoutRst   = 16'd1500;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ADVANCE_MAX_ERR  = 2'd0,
		REG_ADVANCE_TIME     = 2'd1,
		REG_PIVOT_TIMEOUT    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_TRACK   = 3'd0,
		PH_ADVANCE = 3'd1,
		PH_PIVOT_A = 3'd2,
		PH_PIVOT_B = 3'd3,
		PH_HALTED  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		CMD_FOLLOW     = 3'd0,
		CMD_CRUISE     = 3'd1,
		CMD_SPIN_RIGHT = 3'd2,
		CMD_SPIN_LEFT  = 3'd3,
		CMD_BRAKE      = 3'd4
	} cmd_t;

	typedef struct packed {
		logic              line_found;
		logic              centre_seen;
		logic [ErrW-1:0]   track_error;
		logic [1:0]        last_seen_side;
		logic [TimeW-1:0]  now_ms;
	} frame_t;

	typedef struct packed {
		phase_t            phase;
		logic [TimeW-1:0]  phase_start_ms;
		logic              spin_right;
	} state_t;

	typedef struct packed {
		logic [MaxErrW-1:0] adv_err_limit;
		logic [DurW-1:0]    advance_time_ms;
		logic [DurW-1:0]    pivot_limit_ms;
	} cfg_t;

endpackage

### rtl/lrf_cfg.sv
// ----------------------------------------------------------------------------
// lrf_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module lrf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lrf_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [lrf_pkg::CfgW-1:0]      cfg_data,
	output lrf_pkg::cfg_t                 cfg
);

	lrf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adv_err_limit    <= lrf_pkg::AdvanceMaxErrRst;
			cfg_q.advance_time_ms  <= lrf_pkg::AdvanceTimeRst;
			cfg_q.pivot_limit_ms   <= lrf_pkg::PivotTimeoutRst;
		end else if (cfg_we) begin
			case (lrf_pkg::reg_idx_t'(cfg_index))
				lrf_pkg::REG_ADVANCE_MAX_ERR: begin
					cfg_q.adv_err_limit <= cfg_data[lrf_pkg::MaxErrW-1:0];
				end
				lrf_pkg::REG_ADVANCE_TIME: begin
					cfg_q.advance_time_ms <= cfg_data[lrf_pkg::DurW-1:0];
				end
				lrf_pkg::REG_PIVOT_TIMEOUT: begin
					cfg_q.pivot_limit_ms <= cfg_data[lrf_pkg::DurW-1:0];
				end
				default: begin
					cfg_q <= cfg_q;	// unmapped index: ignored
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/lrf_step.sv
// ----------------------------------------------------------------------------
// lrf_step
// Next phase, phase start, pivot direction and motor command for one frame.
// ----------------------------------------------------------------------------
module lrf_step (
	input  lrf_pkg::frame_t  frame,
	input  lrf_pkg::state_t  cur,
	input  lrf_pkg::cfg_t    cfg,
	output lrf_pkg::state_t  nxt,
	output lrf_pkg::cmd_t    cmd
);

	logic [lrf_pkg::ErrW-1:0]  mag;
	logic [lrf_pkg::TimeW-1:0] elapsed;
	logic                      small_err;
	logic                      adv_running;
	logic                      piv_a_running;
	logic                      piv_b_running;
	logic [lrf_pkg::DurW:0]    piv_b_limit;
	logic                      side_right;

	always_comb begin
		// |error|; the most negative code maps to 2048, still fits unsigned
		mag = frame.track_error[lrf_pkg::ErrW-1] ? (~frame.track_error + 1'b1)
			: frame.track_error;
		small_err     = (mag <= {1'b0, cfg.adv_err_limit});
		elapsed       = frame.now_ms - cur.phase_start_ms;
		piv_b_limit   = {cfg.pivot_limit_ms, 1'b0};
		adv_running   = (elapsed < {16'd0, cfg.advance_time_ms});
		piv_a_running = (elapsed < {16'd0, cfg.pivot_limit_ms});
		piv_b_running = (elapsed < {15'd0, piv_b_limit});
		side_right    = ~frame.last_seen_side[1];	// zero or positive -> right
	end

	always_comb begin
		nxt = cur;
		cmd = lrf_pkg::CMD_BRAKE;
		case (cur.phase)
			lrf_pkg::PH_TRACK: begin
				if (frame.line_found) begin
					cmd = lrf_pkg::CMD_FOLLOW;
				end else if (small_err) begin
					nxt.phase          = lrf_pkg::PH_ADVANCE;
					nxt.phase_start_ms = frame.now_ms;
					cmd                = lrf_pkg::CMD_CRUISE;
				end else begin
					nxt.phase          = lrf_pkg::PH_PIVOT_A;
					nxt.phase_start_ms = frame.now_ms;
					nxt.spin_right     = side_right;
					cmd = side_right ? lrf_pkg::CMD_SPIN_RIGHT : lrf_pkg::CMD_SPIN_LEFT;
				end
			end
			lrf_pkg::PH_ADVANCE: begin
				if (frame.line_found) begin
					nxt.phase = lrf_pkg::PH_TRACK;
					cmd       = lrf_pkg::CMD_FOLLOW;
				end else if (adv_running) begin
					cmd = lrf_pkg::CMD_CRUISE;
				end else begin
					nxt.phase          = lrf_pkg::PH_PIVOT_A;
					nxt.phase_start_ms = frame.now_ms;
					nxt.spin_right     = side_right;
					cmd = side_right ? lrf_pkg::CMD_SPIN_RIGHT : lrf_pkg::CMD_SPIN_LEFT;
				end
			end
			lrf_pkg::PH_PIVOT_A: begin
				if (frame.centre_seen) begin
					nxt.phase = lrf_pkg::PH_TRACK;
					cmd       = lrf_pkg::CMD_FOLLOW;
				end else if (piv_a_running) begin
					cmd = cur.spin_right ? lrf_pkg::CMD_SPIN_RIGHT : lrf_pkg::CMD_SPIN_LEFT;
				end else begin
					nxt.phase          = lrf_pkg::PH_PIVOT_B;
					nxt.phase_start_ms = frame.now_ms;
					nxt.spin_right     = ~cur.spin_right;
					cmd = cur.spin_right ? lrf_pkg::CMD_SPIN_LEFT : lrf_pkg::CMD_SPIN_RIGHT;
				end
			end
			lrf_pkg::PH_PIVOT_B: begin
				if (frame.centre_seen) begin
					nxt.phase = lrf_pkg::PH_TRACK;
					cmd       = lrf_pkg::CMD_FOLLOW;
				end else if (piv_b_running) begin
					cmd = cur.spin_right ? lrf_pkg::CMD_SPIN_RIGHT : lrf_pkg::CMD_SPIN_LEFT;
				end else begin
					nxt.phase = lrf_pkg::PH_HALTED;
					cmd       = lrf_pkg::CMD_BRAKE;
				end
			end
			default: begin
				// halted, or an unused code: brake and stay halted
				nxt.phase = lrf_pkg::PH_HALTED;
				cmd       = lrf_pkg::CMD_BRAKE;
			end
		endcase
	end

endmodule

### rtl/line_loss_recovery_fsm_core.sv
// ----------------------------------------------------------------------------
// line_loss_recovery_fsm_core
// Recovery sequencer for a line-following robot: one motor command per frame.
// ----------------------------------------------------------------------------
// Each accepted item is one sensor frame; each frame yields exactly one result
// item carrying a motor command and the phase that holds after the frame.
// Frames pass through the input register, then the result register. One item
// can be taken every cycle while in_stall is low: the phase state is updated
// in the same cycle the frame moves from the input register into the result
// register, so the next frame sees it at once. An output stall only backs up
// the two-entry pipe; in_stall rises when both are full and the result is held.
// Elapsed time is now_ms minus the phase start, modulo 2^32. Once halted,
// the block brakes on every frame until arst_n is asserted. Configuration
// registers (index 0 error limit for advance, 1 advance time, 2 pivot
// timeout) should be written only while no item is in flight.
// ----------------------------------------------------------------------------
module line_loss_recovery_fsm_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [lrf_pkg::CfgIdxW-1:0]          cfg_index,
	input  logic [lrf_pkg::CfgW-1:0]             cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 line_found,
	input  logic                                 centre_seen,
	input  logic signed [lrf_pkg::ErrW-1:0]      track_error,
	input  logic signed [1:0]                    last_seen_side,
	input  logic [lrf_pkg::TimeW-1:0]            now_ms,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [2:0]                           motor_command,
	output logic [2:0]                           phase_out
);

	lrf_pkg::cfg_t   cfg;
	lrf_pkg::frame_t frame_s1;
	logic            valid_s1;
	lrf_pkg::state_t state_q;
	lrf_pkg::state_t state_nxt;
	lrf_pkg::cmd_t   cmd_nxt;
	logic            valid_s2;
	logic [2:0]      cmd_s2;
	logic [2:0]      phase_s2;
	logic            adv_s1;	// s1 item moves into the result register
	logic            in_acc;

	lrf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result slot is free when empty or being taken this cycle
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			frame_s1.line_found     <= line_found;
			frame_s1.centre_seen    <= centre_seen;
			frame_s1.track_error    <= track_error;
			frame_s1.last_seen_side <= last_seen_side;
			frame_s1.now_ms         <= now_ms;
		end
	end

	lrf_step u_step (
		.frame (frame_s1),
		.cur   (state_q),
		.cfg   (cfg),
		.nxt   (state_nxt),
		.cmd   (cmd_nxt)
	);

	// phase state: advances once per frame passed to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase          <= lrf_pkg::PH_TRACK;
			state_q.phase_start_ms <= '0;
			state_q.spin_right     <= 1'b1;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_s2   <= cmd_nxt;
			phase_s2 <= state_nxt.phase;
		end
	end

	assign out_valid     = valid_s2;
	assign motor_command = cmd_s2;
	assign phase_out     = phase_s2;

endmodule
